### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, quiet in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/cprc_pkg.sv
`default_nettype none

package cprc_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W    = 48;
    localparam int COUNT_W   = 16;
    localparam int OP_W      = 3;
    localparam int PAGE_CNT_W = 17;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    // Operation codes
    localparam op_t OP_SET     = 3'd0;
    localparam op_t OP_GET     = 3'd1;
    localparam op_t OP_SHARE   = 3'd2;
    localparam op_t OP_DEC     = 3'd3;
    localparam op_t OP_RELEASE = 3'd4;

    // Configuration register indexes
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_PAGES = 1'b1;

    // Count constants: first share of a singly owned frame gives two owners
    localparam count_t COUNT_MAX   = 16'hFFFF;
    localparam count_t FIRST_SHARE = 16'd2;

endpackage

`default_nettype wire

### rtl/cprc_ram.sv
`default_nettype none

// Single-port RAM with registered read
module cprc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/cprc_alu.sv
`default_nettype none

// Shared add/subtract unit; with operands below 2^(WIDTH-1) the top bit of a
// subtraction is the borrow, i.e. a < b
module cprc_alu #(
    parameter int WIDTH = 49
) (
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic             sub,
    output logic      [WIDTH-1:0] res
);

    always_comb
    begin
        if (sub)
        begin
            res = a - b;
        end
        else
        begin
            res = a + b;
        end
    end

endmodule

`default_nettype wire

### rtl/cow_page_refcount_table.sv
`default_nettype none

// Share-count table for copy-on-write frames: one 16-bit count per frame of
// 2^PAGE_SHIFT bytes, FRAMES frames in an on-chip RAM. After reset the block
// is busy while it sweeps the RAM to zero; configuration writes are taken
// during that sweep and at any idle time. An operation is transferred when
// start is high and busy is low; its result appears with done high for
// exactly one cycle, after three working steps: base subtract, frame limit
// compare with the RAM read, and count update with the RAM write, all
// through one shared adder. busy drops in the done cycle, so the block takes
// no new operation until the last one is done. The result must be taken in
// the done cycle; there is no back-pressure.
module cow_page_refcount_table #(
    parameter int FRAMES     = 65536,
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 48
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire cprc_pkg::op_t           op,
    input  wire cprc_pkg::addr_t         phys_addr,
    input  wire cprc_pkg::count_t        value,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire cprc_pkg::addr_t         cfg_data,
    output logic                         done,
    output cprc_pkg::count_t             count,
    output logic                         in_range,
    output logic                         free_page,
    output logic                         overflow
);

    // Effective address width, frame index widths, limit widths
    localparam int EW = (ADDR_BITS < cprc_pkg::ADDR_W) ? ADDR_BITS : cprc_pkg::ADDR_W;
    localparam int UW = EW + 1;
    localparam int FW = EW - PAGE_SHIFT;
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int XW = (FW > IW) ? FW : IW;
    localparam int LW = $clog2(FRAMES + 1);
    localparam int CW = (LW > cprc_pkg::PAGE_CNT_W) ? LW : cprc_pkg::PAGE_CNT_W;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MAP    = 3'd2;
    localparam logic [2:0] ST_LIMIT  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     clr_idx_reg, clr_idx_next;
    logic              done_reg;
    logic [EW-1:0]     base_reg;
    logic [LW-1:0]     lim_reg;
    logic [CW-1:0]     pages_ext;
    logic [CW-1:0]     lim_cap;

    cprc_pkg::op_t     op_reg;
    logic [EW-1:0]     addr_reg;
    cprc_pkg::count_t  value_reg;
    logic              below_reg;
    logic [FW-1:0]     frame_reg;
    logic              hit_reg;
    cprc_pkg::count_t  count_reg;
    logic              in_range_reg;
    logic              free_reg;
    logic              ovf_reg;

    logic [XW-1:0]     frame_ext;
    logic [UW-1:0]     alu_a, alu_b, alu_res;
    logic              alu_sub;
    logic              ram_we;
    logic [IW-1:0]     ram_addr;
    cprc_pkg::count_t  ram_wdata, ram_rdata;

    cprc_pkg::count_t  cur, step, new_cnt;
    logic              cur_zero, cur_max, cur_ge2, addr_zero, dec_op;
    logic              upd_we, freed, ovf;

    // Shared arithmetic unit
    cprc_alu #(
        .WIDTH (UW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_res)
    );

    // Count store
    cprc_ram #(
        .WIDTH (cprc_pkg::COUNT_W),
        .DEPTH (FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign frame_ext = XW'(frame_reg);

    // Page count capped at the table size when written
    assign pages_ext = CW'(cfg_data[cprc_pkg::PAGE_CNT_W-1:0]);
    assign lim_cap   = (pages_ext > CW'(FRAMES)) ? CW'(FRAMES) : pages_ext;

    // Count update for the operation in hand
    always_comb
    begin
        cur       = hit_reg ? ram_rdata : '0;
        cur_zero  = (cur == '0);
        cur_max   = (cur == cprc_pkg::COUNT_MAX);
        cur_ge2   = |cur[cprc_pkg::COUNT_W-1:1];
        addr_zero = (addr_reg == '0);
        dec_op    = (op_reg == cprc_pkg::OP_DEC) || (op_reg == cprc_pkg::OP_RELEASE);
        step      = alu_res[cprc_pkg::COUNT_W-1:0];
        new_cnt   = cur;
        upd_we    = 1'b0;
        freed     = 1'b0;
        ovf       = 1'b0;
        case (op_reg)
            cprc_pkg::OP_SET:
            begin
                upd_we  = hit_reg;
                new_cnt = value_reg;
            end
            cprc_pkg::OP_SHARE:
            begin
                upd_we = hit_reg;
                if (cur_zero)
                begin
                    new_cnt = cprc_pkg::FIRST_SHARE;
                end
                else if (cur_max)
                begin
                    ovf = hit_reg;
                end
                else
                begin
                    new_cnt = step;
                end
            end
            cprc_pkg::OP_DEC:
            begin
                if (!cur_zero)
                begin
                    upd_we  = hit_reg;
                    new_cnt = step;
                end
            end
            cprc_pkg::OP_RELEASE:
            begin
                // address zero is never released
                if (!addr_zero)
                begin
                    upd_we = hit_reg;
                    if (cur_ge2)
                    begin
                        new_cnt = step;
                    end
                    else
                    begin
                        new_cnt = '0;
                        freed   = 1'b1;
                    end
                end
            end
            default:
            begin
                new_cnt = cur;
            end
        endcase
    end

    // Sequencer: clearing sweep, then map, limit check, update
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        alu_a        = '0;
        alu_b        = '0;
        alu_sub      = 1'b1;
        ram_we       = 1'b0;
        ram_addr     = frame_ext[IW-1:0];
        ram_wdata    = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_idx_reg;
                if (clr_idx_reg == IW'(FRAMES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IW'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                alu_a      = UW'(addr_reg);
                alu_b      = UW'(base_reg);
                state_next = ST_LIMIT;
            end
            ST_LIMIT:
            begin
                alu_a      = UW'(frame_reg);
                alu_b      = UW'(lim_reg);
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                alu_a      = UW'(cur);
                alu_b      = UW'(1);
                alu_sub    = dec_op;
                ram_we     = upd_we;
                ram_wdata  = new_cnt;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            done_reg    <= (state_reg == ST_UPDATE);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            lim_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cprc_pkg::CFG_BASE:  base_reg <= cfg_data[EW-1:0];
                cprc_pkg::CFG_PAGES: lim_reg  <= lim_cap[LW-1:0];
                default:             base_reg <= base_reg;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            op_reg    <= op;
            addr_reg  <= phys_addr[EW-1:0];
            value_reg <= value;
        end
        if (state_reg == ST_MAP)
        begin
            below_reg <= alu_res[UW-1];
            frame_reg <= alu_res[EW-1:PAGE_SHIFT];
        end
        if (state_reg == ST_LIMIT)
        begin
            // tracked when addr >= base and frame < limit
            hit_reg <= !below_reg && alu_res[UW-1];
        end
        if (state_reg == ST_UPDATE)
        begin
            count_reg    <= hit_reg ? new_cnt : '0;
            in_range_reg <= hit_reg;
            free_reg     <= freed;
            ovf_reg      <= ovf;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign count     = count_reg;
    assign in_range  = in_range_reg;
    assign free_page = free_reg;
    assign overflow  = ovf_reg;

endmodule

`default_nettype wire

### rtl/cprc_checker.sv
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the share-count table
module cprc_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire cprc_pkg::count_t count,
    input wire logic             in_range,
    input wire logic             free_page,
    input wire logic             overflow
);

    // a transfer starts work and no result can show in the next cycle
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !done)
    // results come back only once the block is free again
    `ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    // one result per operation
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    // untracked frames report zero and never saturate
    `ASSERT_SAME(a_out_of_range, clk, rst_n, done && !in_range, (count == '0) && !overflow)
    // release and share flags are exclusive
    `ASSERT_SAME(a_flags_excl, clk, rst_n, done, !(free_page && overflow))

endmodule

bind cow_page_refcount_table cprc_checker u_cprc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .count     (count),
    .in_range  (in_range),
    .free_page (free_page),
    .overflow  (overflow)
);

`default_nettype wire

### tb/tb_cow_page_refcount_table.sv
`default_nettype none

module tb_cow_page_refcount_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES     = 65536;
    localparam int PAGE_SHIFT = 12;
    localparam int WD_LIMIT   = 200000;

    // Spare op codes behave as a plain read
    localparam cprc_pkg::op_t OP_FIRST_SPARE = 3'd5;
    localparam cprc_pkg::op_t OP_LAST_SPARE  = 3'd7;

    typedef struct packed {
        cprc_pkg::op_t    op;
        cprc_pkg::addr_t  addr;
        cprc_pkg::count_t val;
    } frame_op_t;

    typedef struct packed {
        cprc_pkg::count_t count;
        logic             in_range;
        logic             free_page;
        logic             overflow;
    } share_result_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    cprc_pkg::op_t    op        = cprc_pkg::OP_GET;
    cprc_pkg::addr_t  phys_addr = '0;
    cprc_pkg::count_t value     = '0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = cprc_pkg::CFG_BASE;
    cprc_pkg::addr_t  cfg_data  = '0;

    logic             busy;
    logic             done;
    cprc_pkg::count_t count;
    logic             in_range;
    logic             free_page;
    logic             overflow;

    cow_page_refcount_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .phys_addr (phys_addr),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .count     (count),
        .in_range  (in_range),
        .free_page (free_page),
        .overflow  (overflow)
    );

    always #2 clk = ~clk;

    // Mirror of the share table and its registers
    cprc_pkg::count_t                frame_counts [FRAMES];
    cprc_pkg::addr_t                 cfg_base  = '0;
    logic [cprc_pkg::PAGE_CNT_W-1:0] cfg_pages = '0;

    frame_op_t     op_queue [$];
    share_result_t expected_q [$];

    int  n_accepted = 0;
    int  n_checked  = 0;
    int  n_errors   = 0;
    int  gap_left   = 0;
    int  wd_count   = 0;
    bit  quiet_tail = 1'b0;
    bit  taken      = 1'b0;

    task automatic report_mismatch(string msg);
        $display("%0t ns: %s", $realtime, msg);
        n_errors++;
    endtask

    // Apply one operation to the mirrored table and give the expected result
    function automatic share_result_t apply_share_op(frame_op_t it);
        share_result_t    res;
        logic [63:0]      lim;
        logic [63:0]      rel;
        logic             hit;
        logic [15:0]      idx;
        cprc_pkg::count_t cur;
        cprc_pkg::count_t cnt;
        logic             freed;
        logic             ovf;
        lim   = (cfg_pages > FRAMES) ? 64'(FRAMES) : 64'(cfg_pages);
        hit   = 1'b0;
        idx   = '0;
        freed = 1'b0;
        ovf   = 1'b0;
        if (it.addr >= cfg_base)
        begin
            rel = ({16'b0, it.addr} - {16'b0, cfg_base}) >> PAGE_SHIFT;
            if (rel < lim)
            begin
                hit = 1'b1;
                idx = rel[15:0];
            end
        end
        cur = hit ? frame_counts[idx] : '0;
        cnt = cur;
        case (it.op)
            cprc_pkg::OP_SET:
            begin
                if (hit)
                begin
                    frame_counts[idx] = it.val;
                    cnt = it.val;
                end
            end
            cprc_pkg::OP_SHARE:
            begin
                if (hit)
                begin
                    if (cur == '0)
                        cnt = cprc_pkg::FIRST_SHARE;
                    else if (cur == cprc_pkg::COUNT_MAX)
                        ovf = 1'b1;
                    else
                        cnt = cur + 16'd1;
                    frame_counts[idx] = cnt;
                end
            end
            cprc_pkg::OP_DEC:
            begin
                if (hit && cur != '0)
                begin
                    cnt = cur - 16'd1;
                    frame_counts[idx] = cnt;
                end
            end
            cprc_pkg::OP_RELEASE:
            begin
                // address zero is never released
                if (it.addr != '0)
                begin
                    if (cur >= 16'd2)
                    begin
                        cnt = cur - 16'd1;
                        frame_counts[idx] = cnt;
                    end
                    else
                    begin
                        if (hit)
                            frame_counts[idx] = '0;
                        cnt   = '0;
                        freed = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.count     = hit ? cnt : '0;
        res.in_range  = hit;
        res.free_page = freed;
        res.overflow  = ovf;
        return res;
    endfunction

    function automatic cprc_pkg::addr_t frame_addr(int unsigned frame, int unsigned off);
        return cfg_base + (cprc_pkg::addr_t'(frame) << PAGE_SHIFT) + cprc_pkg::addr_t'(off);
    endfunction

    // Mostly hot frames so counts build up, plus edges and noise
    function automatic cprc_pkg::addr_t rand_addr();
        int unsigned lim;
        int unsigned pick;
        int unsigned frame;
        lim  = (cfg_pages > FRAMES) ? FRAMES : cfg_pages;
        pick = $urandom_range(0, 99);
        if (pick < 60 && lim > 0)
        begin
            if (pick < 45)
                frame = $urandom_range(0, ((lim < 6) ? lim : 6) - 1);
            else
                frame = $urandom_range(0, lim - 1);
            return frame_addr(frame, $urandom_range(0, 4095));
        end
        else if (pick < 70)
        begin
            frame = (lim > 0) ? lim - 1 + $urandom_range(0, 2) : $urandom_range(0, 2);
            return frame_addr(frame, $urandom_range(0, 4095));
        end
        else if (pick < 78)
            return cfg_base - cprc_pkg::addr_t'($urandom_range(1, 8192));
        else if (pick < 84)
            return '0;
        else if (pick < 90)
        begin
            case ($urandom_range(0, 2))
                0:       return '1;
                1:       return cfg_base;
                default: return cfg_base + cprc_pkg::addr_t'(4095);
            endcase
        end
        return cprc_pkg::addr_t'({$urandom(), $urandom()});
    endfunction

    function automatic frame_op_t rand_op();
        frame_op_t it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            it.op = cprc_pkg::OP_SET;
        else if (pick < 22)
            it.op = cprc_pkg::OP_GET;
        else if (pick < 52)
            it.op = cprc_pkg::OP_SHARE;
        else if (pick < 67)
            it.op = cprc_pkg::OP_DEC;
        else if (pick < 92)
            it.op = cprc_pkg::OP_RELEASE;
        else
            it.op = cprc_pkg::op_t'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
        it.addr = rand_addr();
        pick = $urandom_range(0, 9);
        if (pick < 5)
            it.val = cprc_pkg::count_t'($urandom_range(0, 2));
        else if (pick == 5)
            it.val = cprc_pkg::COUNT_MAX;
        else if (pick == 6)
            it.val = cprc_pkg::COUNT_MAX - 16'd1;
        else
            it.val = cprc_pkg::count_t'($urandom());
        return it;
    endfunction

    task automatic push_op(cprc_pkg::op_t o, cprc_pkg::addr_t a, cprc_pkg::count_t v);
        frame_op_t it;
        it.op   = o;
        it.addr = a;
        it.val  = v;
        op_queue.push_back(it);
    endtask

    task automatic push_random(int n);
        repeat (n)
            op_queue.push_back(rand_op());
    endtask

    // Register write, with the mirror following it
    task automatic cfg_write(logic idx, cprc_pkg::addr_t data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == cprc_pkg::CFG_BASE)
            cfg_base = data;
        else
            cfg_pages = data[cprc_pkg::PAGE_CNT_W-1:0];
    endtask

    // Block until every queued operation has been transferred and answered
    task automatic wait_idle();
        do
            @(posedge clk);
        while (!(op_queue.size() == 0 && !start && n_accepted == n_checked));
    endtask

    task automatic set_phase(cprc_pkg::addr_t base, logic [cprc_pkg::PAGE_CNT_W-1:0] pages);
        wait_idle();
        cfg_write(cprc_pkg::CFG_BASE, base);
        cfg_write(cprc_pkg::CFG_PAGES, cprc_pkg::addr_t'(pages));
        @(posedge clk);
    endtask

    // Driver: presents queued operations, with random bursts of idle cycles
    always @(negedge clk)
    begin
        frame_op_t it;
        logic      go;
        if (!(start && !taken))
        begin
            go = 1'b0;
            if (gap_left > 0 && !quiet_tail)
                gap_left--;
            else if (op_queue.size() > 0)
            begin
                it        = op_queue.pop_front();
                op        <= it.op;
                phys_addr <= it.addr;
                value     <= it.val;
                go        = 1'b1;
                if (!quiet_tail && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 15);
            end
            start <= go;
        end
    end

    // Monitor: checks each result, then records any transfer taken this edge
    always @(posedge clk)
    begin
        share_result_t exp_r;
        frame_op_t     it;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no operation outstanding");
            else
            begin
                exp_r = expected_q.pop_front();
                n_checked <= n_checked + 1;
                if (count !== exp_r.count)
                    report_mismatch($sformatf("count expected %0h got %0h",
                                              exp_r.count, count));
                if (in_range !== exp_r.in_range)
                    report_mismatch($sformatf("in_range expected %0b got %0b",
                                              exp_r.in_range, in_range));
                if (free_page !== exp_r.free_page)
                    report_mismatch($sformatf("free_page expected %0b got %0b",
                                              exp_r.free_page, free_page));
                if (overflow !== exp_r.overflow)
                    report_mismatch($sformatf("overflow expected %0b got %0b",
                                              exp_r.overflow, overflow));
            end
        end
        if (rst_n && start && !busy)
        begin
            it.op   = op;
            it.addr = phys_addr;
            it.val  = value;
            expected_q.push_back(apply_share_op(it));
            n_accepted <= n_accepted + 1;
            taken      <= 1'b1;
        end
        else
            taken <= 1'b0;
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || (rst_n && done))
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        foreach (frame_counts[i])
            frame_counts[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: small table at an aligned base
        set_phase(48'h0000_1234_5000, 17'd32);
        push_op(cprc_pkg::OP_GET, frame_addr(0, 0), '0);
        push_op(cprc_pkg::OP_SHARE, frame_addr(0, 12'h123), '0);
        push_op(cprc_pkg::OP_SHARE, frame_addr(0, 4095), '0);
        push_op(cprc_pkg::OP_DEC, frame_addr(0, 0), '0);
        push_op(cprc_pkg::OP_RELEASE, frame_addr(0, 7), '0);
        push_op(cprc_pkg::OP_RELEASE, frame_addr(0, 8), '0);
        push_op(cprc_pkg::OP_RELEASE, frame_addr(0, 9), '0);
        push_op(cprc_pkg::OP_DEC, frame_addr(0, 0), '0);
        push_op(cprc_pkg::OP_SET, frame_addr(31, 0), cprc_pkg::COUNT_MAX);
        push_op(cprc_pkg::OP_SHARE, frame_addr(31, 4095), '0);
        push_op(cprc_pkg::OP_GET, frame_addr(31, 1), '0);
        push_op(cprc_pkg::OP_SET, frame_addr(31, 2), cprc_pkg::COUNT_MAX - 16'd1);
        push_op(cprc_pkg::OP_SHARE, frame_addr(31, 3), '0);
        push_op(cprc_pkg::OP_GET, frame_addr(32, 0), '0);
        push_op(cprc_pkg::OP_SHARE, cfg_base - cprc_pkg::addr_t'(1), '0);
        push_op(cprc_pkg::OP_RELEASE, '0, '0);
        push_op(cprc_pkg::OP_RELEASE, frame_addr(32, 5), '0);
        push_op(cprc_pkg::OP_SET, frame_addr(1, 0), 16'd1);
        push_op(cprc_pkg::OP_RELEASE, frame_addr(1, 0), '0);
        push_op(cprc_pkg::OP_SET, frame_addr(2, 0), 16'hA5C3);
        push_op(OP_FIRST_SPARE, frame_addr(2, 0), 16'h5A3C);
        push_op(cprc_pkg::op_t'(OP_FIRST_SPARE + 3'd1), frame_addr(2, 0), '1);
        push_op(OP_LAST_SPARE, frame_addr(2, 0), '0);
        push_op(cprc_pkg::OP_GET, '1, '0);
        push_random(60);

        // Tracking disabled
        set_phase('0, '0);
        push_random(50);

        // Whole table from address zero; release of address zero keeps its count
        set_phase('0, 17'd65536);
        push_op(cprc_pkg::OP_SET, '0, 16'd3);
        push_op(cprc_pkg::OP_RELEASE, '0, '0);
        push_op(cprc_pkg::OP_GET, '0, '0);
        push_random(240);

        // Bases at the top of the address space
        set_phase(48'hFFFF_FFFF_F000, 17'd65536);
        push_random(60);
        set_phase('1, 17'd65536);
        push_random(40);

        // Page count beyond the table size, unaligned base
        set_phase(48'h0007_5555_5A3C, '1);
        push_random(150);

        // Random aligned bases with small tables
        repeat (5)
        begin
            set_phase(cprc_pkg::addr_t'({$urandom(), $urandom()}) & 48'hFFFF_FFFF_F000,
                      17'($urandom_range(1, 64)));
            push_random(50);
        end

        // Back to back, no idle cycles
        set_phase(cprc_pkg::addr_t'({$urandom(), $urandom()}), 17'($urandom_range(1, 3)));
        quiet_tail = 1'b1;
        push_random(175);

        wait_idle();
        repeat (8) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
